### sv/mbe_pkg.sv
// Shared types and constants for the modular binomial block.
package mbe_pkg;

  localparam int MOD_W = 31;
  localparam int IN_W  = 16;
  localparam int CNT_W = $clog2(MOD_W);

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MOD_W - 1);

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FACT,
    S_FACT_W,
    S_PROD,
    S_PROD_W,
    S_EG,
    S_DIV_W,
    S_SMUL,
    S_SMUL_W,
    S_FIN,
    S_FIN_W,
    S_DONE
  } state_t;

endpackage

### sv/mbe_alu.sv
// Bit-serial shared unit: modular multiply (a*b mod p) and restoring divide (a/b).
module mbe_alu
  import mbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  alu_cmd_t         cmd,
  input  logic [MOD_W-1:0] a,
  input  logic [MOD_W-1:0] b,
  input  logic [MOD_W-1:0] modulus,
  output logic             done,
  output logic [MOD_W-1:0] res,
  output logic [MOD_W-1:0] quot
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  alu_op_t          op_r, op_nxt;
  logic [MOD_W-1:0] a_r, a_nxt;
  logic [MOD_W-1:0] d_r, d_nxt;
  logic [MOD_W-1:0] acc_r, acc_nxt;
  logic [MOD_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [MOD_W:0]   t1, s1, t2, r2;
  logic             ge;

  always_comb begin
    // shared shift and compare-subtract
    t1 = {acc_r, (op_r == OP_DIV) ? sh_r[MOD_W-1] : 1'b0};
    ge = t1 >= {1'b0, d_r};
    s1 = ge ? t1 - {1'b0, d_r} : t1;
    // conditional add of the multiplicand, then reduce
    t2 = {1'b0, s1[MOD_W-1:0]} + (sh_r[MOD_W-1] ? {1'b0, a_r} : '0);
    r2 = (t2 >= {1'b0, d_r}) ? t2 - {1'b0, d_r} : t2;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    a_nxt    = a_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    if (cmd.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      a_nxt    = a;
      d_nxt    = (cmd.op == OP_DIV) ? b : modulus;
      acc_nxt  = '0;
      sh_nxt   = (cmd.op == OP_DIV) ? a : b;
      cnt_nxt  = LAST_STEP;
    end else if (busy_r) begin
      acc_nxt = (op_r == OP_DIV) ? s1[MOD_W-1:0] : r2[MOD_W-1:0];
      sh_nxt  = {sh_r[MOD_W-2:0], (op_r == OP_DIV) ? ge : 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;
  assign quot = sh_r;

endmodule

### sv/modular_binomial_extgcd.sv
// Top level: C(n,m) mod p through factorials and an extended Euclidean inverse.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the modulus p; it is
//   always ready; the user writes it only while idle; the block does not check.
//   in channel takes one beat of n and m; in_ready is high only in idle.
//   out channel returns one beat: result = C(n,m) mod p, no_inverse flag.
// Cost: each modular multiply or divide is one pass of the shared
//   bit-serial unit (an issue, 31 bit steps, then a done pulse).
//   An item costs n multiplies for the factorial sweep, one to combine m!
//   and (n-m)!, then per Euclid step one divide and one multiply, and one
//   final multiply, with up to about 45 Euclid steps.
//   m > n or p < 2 skip the unit and go from idle straight to the done state.
// Flow: one item at a time; the shared unit sets the pace.
// Reset: modulus returns to 1000000007, sequencer to idle, no result held.
// Stall: the result waits in the output register while out_ready is low;
//   the next beat is accepted only after the sequencer delivers it.
module modular_binomial_extgcd
  import mbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MOD_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_n_value,
  input  logic [IN_W-1:0]  in_k_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [MOD_W-1:0] out_result,
  output logic             out_no_inverse
);

  state_t           state_r, state_nxt;
  logic [MOD_W-1:0] modulus_r;
  logic             out_valid_r, out_valid_nxt;
  logic [MOD_W-1:0] out_result_r, out_result_nxt;
  logic             out_flag_r, out_flag_nxt;

  logic [IN_W-1:0]  n_r, n_nxt, m_r, m_nxt, nm_r, nm_nxt, i_r, i_nxt;
  logic [MOD_W-1:0] acc_r, acc_nxt, fm_r, fm_nxt, fr_r, fr_nxt;
  logic [MOD_W-1:0] r0_r, r0_nxt, r1_r, r1_nxt, s0_r, s0_nxt, s1_r, s1_nxt;
  logic [MOD_W-1:0] q_r, q_nxt, res_r, res_nxt;
  logic             flag_r, flag_nxt;

  alu_cmd_t         alu_cmd;
  logic [MOD_W-1:0] alu_a, alu_b, alu_res, alu_quot;
  logic             alu_done;

  logic             in_beat, out_load;

  mbe_alu u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (alu_cmd),
    .a       (alu_a),
    .b       (alu_b),
    .modulus (modulus_r),
    .done    (alu_done),
    .res     (alu_res),
    .quot    (alu_quot)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_k_value > in_n_value || modulus_r < MOD_W'(2)) state_nxt = S_DONE;
          else if (in_n_value == '0) state_nxt = S_PROD;
          else state_nxt = S_FACT;
        end
      end
      S_FACT:   state_nxt = S_FACT_W;
      S_FACT_W: begin
        if (alu_done) state_nxt = (i_r == n_r) ? S_PROD : S_FACT;
      end
      S_PROD:   state_nxt = S_PROD_W;
      S_PROD_W: if (alu_done) state_nxt = S_EG;
      S_EG: begin
        if (r1_r != '0) state_nxt = S_DIV_W;
        else if (r0_r == MOD_W'(1)) state_nxt = S_FIN;
        else state_nxt = S_DONE;
      end
      S_DIV_W:  if (alu_done) state_nxt = S_SMUL;
      S_SMUL:   state_nxt = S_SMUL_W;
      S_SMUL_W: if (alu_done) state_nxt = S_EG;
      S_FIN:    state_nxt = S_FIN_W;
      S_FIN_W:  if (alu_done) state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and unit commands
  always_comb begin
    n_nxt    = n_r;
    m_nxt    = m_r;
    nm_nxt   = nm_r;
    i_nxt    = i_r;
    acc_nxt  = acc_r;
    fm_nxt   = fm_r;
    fr_nxt   = fr_r;
    r0_nxt   = r0_r;
    r1_nxt   = r1_r;
    s0_nxt   = s0_r;
    s1_nxt   = s1_r;
    q_nxt    = q_r;
    res_nxt  = res_r;
    flag_nxt = flag_r;
    alu_cmd  = '{start: 1'b0, op: OP_MUL};
    alu_a    = acc_r;
    alu_b    = {{(MOD_W-IN_W){1'b0}}, i_r};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt    = in_n_value;
          m_nxt    = in_k_value;
          nm_nxt   = in_n_value - in_k_value;
          i_nxt    = IN_W'(1);
          acc_nxt  = MOD_W'(1);
          fm_nxt   = MOD_W'(1);
          fr_nxt   = MOD_W'(1);
          res_nxt  = '0;
          // m > n gives a plain zero; p below two flags a missing inverse
          flag_nxt = !(in_k_value > in_n_value) && (modulus_r < MOD_W'(2));
        end
      end
      S_FACT: alu_cmd = '{start: 1'b1, op: OP_MUL};
      S_FACT_W: begin
        if (alu_done) begin
          acc_nxt = alu_res;
          if (i_r == m_r) fm_nxt = alu_res;
          if (i_r == nm_r) fr_nxt = alu_res;
          i_nxt = i_r + 1'b1;
        end
      end
      S_PROD: begin
        // m! and (n-m)! are both invertible exactly when their product is
        alu_cmd = '{start: 1'b1, op: OP_MUL};
        alu_a   = fm_r;
        alu_b   = fr_r;
      end
      S_PROD_W: begin
        if (alu_done) begin
          r0_nxt = alu_res;
          r1_nxt = modulus_r;
          s0_nxt = MOD_W'(1);
          s1_nxt = '0;
        end
      end
      S_EG: begin
        if (r1_r != '0) begin
          alu_cmd = '{start: 1'b1, op: OP_DIV};
          alu_a   = r0_r;
          alu_b   = r1_r;
        end else if (r0_r != MOD_W'(1)) begin
          res_nxt  = '0;
          flag_nxt = 1'b1;
        end
      end
      S_DIV_W: begin
        if (alu_done) begin
          r0_nxt = r1_r;
          r1_nxt = alu_res;
          q_nxt  = alu_quot;
        end
      end
      S_SMUL: begin
        alu_cmd = '{start: 1'b1, op: OP_MUL};
        alu_a   = s1_r;
        alu_b   = q_r;
      end
      S_SMUL_W: begin
        if (alu_done) begin
          // s1 <- s0 - q*s1 mod p, all kept in [0, p)
          s0_nxt = s1_r;
          s1_nxt = (s0_r >= alu_res) ? s0_r - alu_res
                                     : s0_r + (modulus_r - alu_res);
        end
      end
      S_FIN: begin
        alu_cmd = '{start: 1'b1, op: OP_MUL};
        alu_a   = acc_r;
        alu_b   = s0_r;
      end
      S_FIN_W: begin
        if (alu_done) begin
          res_nxt  = alu_res;
          flag_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    out_flag_nxt   = out_flag_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_result_nxt = res_r;
      out_flag_nxt   = flag_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) modulus_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
    out_flag_r   <= out_flag_nxt;
    n_r    <= n_nxt;
    m_r    <= m_nxt;
    nm_r   <= nm_nxt;
    i_r    <= i_nxt;
    acc_r  <= acc_nxt;
    fm_r   <= fm_nxt;
    fr_r   <= fr_nxt;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    s0_r   <= s0_nxt;
    s1_r   <= s1_nxt;
    q_r    <= q_nxt;
    res_r  <= res_nxt;
    flag_r <= flag_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_result     = out_result_r;
  assign out_no_inverse = out_flag_r;

  // a flagged result is always zero
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flag_r |-> out_result_r == '0)
    else $error("no_inverse with nonzero result");

  // the unit only finishes while the sequencer waits on it
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> (state_r == S_FACT_W || state_r == S_PROD_W ||
                  state_r == S_DIV_W || state_r == S_SMUL_W || state_r == S_FIN_W))
    else $error("unit finished outside a wait state");

  // an accepted beat always starts work away from idle
  a_beat_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> state_r != S_IDLE)
    else $error("accepted beat left sequencer idle");

  // delivered residues stay below the modulus
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_result_r < modulus_r || out_result_r == '0))
    else $error("result not reduced");

endmodule

### tb/modular_binomial_extgcd_tb.sv
// Self-checking testbench for the modular binomial block.
//
// A directed table exercises the corner cases first. Rows whose answer is
// obvious carry their expected values; all other rows go through the local
// predictor. Random beats follow under several moduli: primes, a composite,
// a very small prime, the largest 31-bit value, and the out-of-range values
// 0 and 1. The sender works in bursts and the receiver stalls on its own
// pattern. One phase holds the receiver off for a long stretch. Every result
// beat is compared field by field with the oldest pending expectation.
module modular_binomial_extgcd_tb;
  import mbe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_N     = 65535;
  localparam longint      CYCLE_CAP = 40_000_000;
  localparam int          HOLD_LEN  = 40000;
  localparam int          DRAIN_GAP = 60;

  typedef struct {
    logic [MOD_W-1:0] result;
    logic             no_inverse;
  } binom_t;

  typedef struct {
    int unsigned      n;
    int unsigned      k;
    bit               typed;
    logic [MOD_W-1:0] result;
    logic             no_inverse;
  } binom_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [MOD_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [IN_W-1:0]  in_n_value;
  logic [IN_W-1:0]  in_k_value;
  logic             out_valid;
  logic             out_ready;
  logic [MOD_W-1:0] out_result;
  logic             out_no_inverse;

  // Local copy of the modulus register, updated on each accepted cfg beat.
  logic [MOD_W-1:0] modulus_shadow;
  binom_t           pending_binoms[$];
  int               mismatch_count;
  int               beats_sent;
  int               beats_checked;
  int               flag_beats;
  longint           cycle_count;
  int               burst_left;
  bit               hold_req;
  int               hold_left;

  modular_binomial_extgcd DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_n_value     (in_n_value),
    .in_k_value     (in_k_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_no_inverse (out_no_inverse)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Inverse of t modulo p by extended Euclid; ok drops when gcd is not 1.
  function automatic bit inv_mod(longint t, longint p, output longint inv);
    longint r0, r1, s0, s1, q, tr, ts;
    r0 = t;
    r1 = p;
    s0 = 1;
    s1 = 0;
    inv = 0;
    while (r1 != 0) begin
      q  = r0 / r1;
      tr = r0 - q * r1;
      ts = s0 - q * s1;
      r0 = r1;
      r1 = tr;
      s0 = s1;
      s1 = ts;
    end
    if (r0 != 1) return 1'b0;
    inv = ((s0 % p) + p) % p;
    return 1'b1;
  endfunction

  // C(n,k) mod p from factorials and two modular inverses.
  function automatic binom_t binom_mod(int unsigned n, int unsigned k,
                                       logic [MOD_W-1:0] pmod);
    binom_t b;
    longint p, fn, fk, fr, ik, ir, acc;
    bit     okk, okr;
    b.result     = '0;
    b.no_inverse = 1'b0;
    p = longint'(pmod);
    if (k > n) return b;
    if (p < 2) begin
      b.no_inverse = 1'b1;
      return b;
    end
    if (n > MAX_N) return b;
    fn = 1 % p;
    fk = 1 % p;
    fr = 1 % p;
    for (int unsigned i = 1; i <= n; i++) begin
      fn = (fn * longint'(i)) % p;
      if (i == k)     fk = fn;
      if (i == n - k) fr = fn;
    end
    okk = inv_mod(fk, p, ik);
    okr = inv_mod(fr, p, ir);
    if (okk && okr) begin
      acc = (fn * ik) % p;
      acc = (acc * ir) % p;
      b.result = acc[MOD_W-1:0];
    end else begin
      b.no_inverse = 1'b1;
    end
    return b;
  endfunction

  // Directed rows; typed answers hold for the reset modulus 1000000007.
  binom_row_t directed_rows[] = '{
    '{0,     0,     1, 31'd1,     1'b0},
    '{5,     6,     1, 31'd0,     1'b0},
    '{0,     65535, 1, 31'd0,     1'b0},
    '{65534, 65535, 1, 31'd0,     1'b0},
    '{1,     0,     1, 31'd1,     1'b0},
    '{1,     1,     1, 31'd1,     1'b0},
    '{5,     2,     1, 31'd10,    1'b0},
    '{10,    3,     1, 31'd120,   1'b0},
    '{20,    10,    0, 31'd0,     1'b0},
    '{33,    17,    0, 31'd0,     1'b0},
    '{40,    0,     1, 31'd1,     1'b0},
    '{40,    40,    1, 31'd1,     1'b0},
    '{300,   150,   0, 31'd0,     1'b0},
    '{65535, 65535, 1, 31'd1,     1'b0}
  };

  // Offer one beat; hold valid and payload until it is taken.
  task automatic send_binom(int unsigned n, int unsigned k, bit typed,
                            binom_t typed_exp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_n_value <= IN_W'(n);
    in_k_value <= IN_W'(k);
    do @(posedge clk); while (!in_ready);
    pending_binoms.push_back(typed ? typed_exp : binom_mod(n, k, modulus_shadow));
    beats_sent++;
  endtask

  // Drop valid and wait until every pending result has been checked.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_binoms.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Write the modulus; called only when the block is idle.
  task automatic write_modulus(logic [MOD_W-1:0] p);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    modulus_shadow = p;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random beat: mostly small well-formed n >= k, some k > n with wide
  // values to toggle the upper input bits, and a few mid-size n.
  task automatic send_random;
    int unsigned n, k;
    binom_t      none;
    int          pick;
    none = '{default: '0};
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      n = $urandom_range(0, 65534);
      k = $urandom_range(n + 1, 65535);
    end else if (pick == 2) begin
      n = $urandom_range(0, 48);
      k = $urandom_range(0, 1) ? n : 0;
    end else if (pick == 3 && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(49, 400);
      k = $urandom_range(0, n);
    end else begin
      n = $urandom_range(0, 48);
      k = $urandom_range(0, n);
    end
    send_binom(n, k, 1'b0, none);
  endtask

  // Receiver: random stall pattern, long hold-off when requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (cycle_count[9:7] == 3'd5) begin
      // A quiet stretch with no stalls.
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check every result beat against the oldest expectation.
  always @(posedge clk) begin
    binom_t exp_b;
    if (rst_n && out_valid && out_ready) begin
      if (pending_binoms.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat result=%0d no_inverse=%0b",
                 $time, out_result, out_no_inverse);
      end else begin
        exp_b = pending_binoms.pop_front();
        beats_checked++;
        if (exp_b.no_inverse) flag_beats++;
        if (out_result !== exp_b.result) begin
          mismatch_count++;
          $display("%0t: result mismatch expected=%0d actual=%0d",
                   $time, exp_b.result, out_result);
        end
        if (out_no_inverse !== exp_b.no_inverse) begin
          mismatch_count++;
          $display("%0t: no_inverse mismatch expected=%0b actual=%0b",
                   $time, exp_b.no_inverse, out_no_inverse);
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [MOD_W-1:0] moduli[];
    binom_t row_exp;
    moduli         = '{31'd2147483647, 31'd13, 31'd1000, 31'd2,
                       31'd1, 31'd0, 31'd65537, 31'd0};
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_n_value     = '0;
    in_k_value     = '0;
    out_ready      = 1'b0;
    mismatch_count = 0;
    beats_sent     = 0;
    beats_checked  = 0;
    flag_beats     = 0;
    cycle_count    = 0;
    burst_left     = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    modulus_shadow = MOD_RESET;
    moduli[moduli.size() - 1] = MOD_W'($urandom_range(2, 2147483647));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table under the reset modulus.
    foreach (directed_rows[i]) begin
      row_exp.result     = directed_rows[i].result;
      row_exp.no_inverse = directed_rows[i].no_inverse;
      send_binom(directed_rows[i].n, directed_rows[i].k,
                 directed_rows[i].typed, row_exp);
    end
    drain();

    // Random phases, one per modulus; the first holds the receiver off.
    foreach (moduli[i]) begin
      write_modulus(moduli[i]);
      if (i == 0) hold_req = 1'b1;
      repeat (11) send_random();
      drain();
    end
    // Back to a large prime with a burst of random beats.
    write_modulus(31'd1000000007);
    repeat (12) send_random();
    drain();

    $display("covered %0d beats, %0d checked, %0d with no_inverse set,",
             beats_sent, beats_checked, flag_beats);
    $display("over %0d moduli including 0, 1, 2 and 2^31-1", moduli.size() + 1);
    if (mismatch_count == 0 && pending_binoms.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
sv/mbe_pkg.sv
sv/mbe_alu.sv
sv/modular_binomial_extgcd.sv
tb/modular_binomial_extgcd_tb.sv
